// ===== rtl/pss_pkg.sv =====
// shared types and constants for the point store search block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pss_pkg;

   localparam int INDEX_BITS = 6;
   localparam int DIST_BITS  = 41;

   localparam logic [DIST_BITS-1:0] RADIUS_RESET = 41'd147456;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_INSERT  = 2'd1,
      OP_NEAREST = 2'd2,
      OP_RADIUS  = 2'd3
   } op_type;

   // control token that travels with each scanned point
   typedef struct packed {
      logic                  valid;
      logic                  fin;
      logic [INDEX_BITS-1:0] idx;
   } tag_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] index;
      logic [DIST_BITS-1:0]  dist_squared;
      logic                  hit;
      logic                  last;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/pss_if.sv =====
// valid/ready channel interfaces for request and response transactions
// depends on pss_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pss_req_if #(
   parameter int COORD_BITS = 20
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   op;
   logic signed [COORD_BITS-1:0] px;
   logic signed [COORD_BITS-1:0] py;

   modport source (output valid, output op, output px, output py, input ready);
   modport sink   (input valid, input op, input px, input py, output ready);
endinterface

interface pss_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pss_pkg::INDEX_BITS-1:0]   index;
   logic [pss_pkg::DIST_BITS-1:0]    dist_squared;
   logic                             hit;
   logic                             last;

   modport source (output valid, output index, output dist_squared, output hit, output last,
                   input ready);
   modport sink   (input valid, input index, input dist_squared, input hit, input last,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/pss_point_mem.sv =====
// point coordinate memory, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module pss_point_mem #(
   parameter int CAPACITY   = 64,
   parameter int COORD_BITS = 20,
   parameter int AW         = 6
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [COORD_BITS-1:0] wr_x,
   input  wire logic [COORD_BITS-1:0] wr_y,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output logic      [COORD_BITS-1:0] rd_x,
   output logic      [COORD_BITS-1:0] rd_y
);

   logic [COORD_BITS-1:0] mem_x_ff [CAPACITY];
   logic [COORD_BITS-1:0] mem_y_ff [CAPACITY];
   logic [COORD_BITS-1:0] rd_x_ff;
   logic [COORD_BITS-1:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x_ff[wr_addr] <= wr_x;
         mem_y_ff[wr_addr] <= wr_y;
      end
      if (rd_en) begin
         rd_x_ff <= mem_x_ff[rd_addr];
         rd_y_ff <= mem_y_ff[rd_addr];
      end
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

`default_nettype wire

// ===== rtl/pss_dist_pipe.sv =====
// distance pipeline: absolute differences, then registered squares
// depends on pss_pkg for the token type
`timescale 1ns / 1ps
`default_nettype none

module pss_dist_pipe #(
   parameter int COORD_BITS = 20
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire pss_pkg::tag_type          tag_in,
   input  wire logic [COORD_BITS-1:0]     pt_x,
   input  wire logic [COORD_BITS-1:0]     pt_y,
   input  wire logic [COORD_BITS-1:0]     qx,
   input  wire logic [COORD_BITS-1:0]     qy,
   output pss_pkg::tag_type               tag_out,
   output logic      [2*COORD_BITS-1:0]   sq_x,
   output logic      [2*COORD_BITS-1:0]   sq_y
);

   localparam int C = COORD_BITS;

   logic [C:0]      diff_x;
   logic [C:0]      diff_y;
   logic [C:0]      abs_x;
   logic [C:0]      abs_y;
   pss_pkg::tag_type s2_tag_ff;
   pss_pkg::tag_type s3_tag_ff;
   logic [C-1:0]    dx_ff;
   logic [C-1:0]    dy_ff;
   logic [2*C-1:0]  sq_x_ff;
   logic [2*C-1:0]  sq_y_ff;

   // sign-extend by one bit so the difference cannot overflow
   assign diff_x = {pt_x[C-1], pt_x} - {qx[C-1], qx};
   assign diff_y = {pt_y[C-1], pt_y} - {qy[C-1], qy};
   assign abs_x  = diff_x[C] ? (~diff_x + (C+1)'(1)) : diff_x;
   assign abs_y  = diff_y[C] ? (~diff_y + (C+1)'(1)) : diff_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else if (adv) begin
         s2_tag_ff <= tag_in;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff   <= abs_x[C-1:0];
         dy_ff   <= abs_y[C-1:0];
         sq_x_ff <= dx_ff * dx_ff;
         sq_y_ff <= dy_ff * dy_ff;
      end
   end

   assign tag_out = s3_tag_ff;
   assign sq_x    = sq_x_ff;
   assign sq_y    = sq_y_ff;

endmodule

`default_nettype wire

// ===== rtl/pss_select.sv =====
// result selection: running minimum for nearest, held match for radius
// depends on pss_pkg for token and result types
`timescale 1ns / 1ps
`default_nettype none

module pss_select #(
   parameter int COORD_BITS = 20,
   parameter int SUM_BITS   = 41
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire logic                             mode_radius,
   input  wire logic [pss_pkg::DIST_BITS-1:0]    radius_squared,
   input  wire pss_pkg::tag_type                 tag_in,
   input  wire logic [2*COORD_BITS-1:0]          sq_x,
   input  wire logic [2*COORD_BITS-1:0]          sq_y,
   output logic                                  emit,
   output logic                                  done,
   output pss_pkg::result_type                   result
);

   logic [SUM_BITS-1:0]              sum;
   logic [SUM_BITS-1:0]              radius_ext;
   logic                             better;
   logic                             match;
   logic [SUM_BITS-1:0]              best_d_ff;
   logic [pss_pkg::INDEX_BITS-1:0]   best_idx_ff;
   logic                             pend_valid_ff;
   logic [SUM_BITS-1:0]              pend_d_ff;
   logic [pss_pkg::INDEX_BITS-1:0]   pend_idx_ff;

   assign sum        = SUM_BITS'(sq_x) + SUM_BITS'(sq_y);
   assign radius_ext = SUM_BITS'(radius_squared);
   // first point always seeds the minimum, ties keep the lower index
   assign better     = (tag_in.idx == '0) || (sum < best_d_ff);
   assign match      = sum <= radius_ext;
   assign done       = tag_in.valid && tag_in.fin;

   always_comb begin
      emit   = 1'b0;
      result = '{index: '0, dist_squared: '0, hit: 1'b0, last: 1'b1};
      if (tag_in.valid) begin
         if (tag_in.fin) begin
            emit = 1'b1;
            if (!mode_radius) begin
               result = '{index: best_idx_ff,
                          dist_squared: pss_pkg::DIST_BITS'(best_d_ff),
                          hit: 1'b1, last: 1'b1};
            end else if (pend_valid_ff) begin
               result = '{index: pend_idx_ff,
                          dist_squared: pss_pkg::DIST_BITS'(pend_d_ff),
                          hit: 1'b1, last: 1'b1};
            end
         end else if (mode_radius && match && pend_valid_ff) begin
            // a newer match proves the held one is not the final one
            emit   = 1'b1;
            result = '{index: pend_idx_ff,
                       dist_squared: pss_pkg::DIST_BITS'(pend_d_ff),
                       hit: 1'b1, last: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (adv && tag_in.valid) begin
         if (tag_in.fin) begin
            pend_valid_ff <= 1'b0;
         end else if (mode_radius && match) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && tag_in.valid && !tag_in.fin) begin
         if (!mode_radius && better) begin
            best_d_ff   <= sum;
            best_idx_ff <= tag_in.idx;
         end
         if (mode_radius && match) begin
            pend_d_ff   <= sum;
            pend_idx_ff <= tag_in.idx;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/point_store_nearest_and_radius_search_top.sv =====
// clear and insert are accepted without leaving idle; an insert response is registered at acceptance
// a query reads each stored point in turn, then issues a closing token and drains the pipe before
// the next acceptance; its last response is registered as the closing token leaves selection
// a response passes the read, difference and square registers; stalls freeze the pipe
// synchronous active-high reset empties the store and sets radius_squared to 147456
// depends on pss_pkg, pss_if, pss_point_mem, pss_dist_pipe, pss_select
`timescale 1ns / 1ps
`default_nettype none

module point_store_nearest_and_radius_search_top #(
   parameter int CAPACITY   = 64,
   parameter int COORD_BITS = 20
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   pss_req_if.sink                             req_chan,
   pss_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [pss_pkg::DIST_BITS-1:0]  csr_wdata
);

   localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int SUM_BITS = (2*COORD_BITS+1 > pss_pkg::DIST_BITS) ?
                             2*COORD_BITS+1 : pss_pkg::DIST_BITS;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_WAIT
   } state_type;

   state_type                      state_ff,      state_in;
   logic [CW-1:0]                  count_ff,      count_in;
   logic [CW-1:0]                  addr_ff,       addr_in;
   logic [COORD_BITS-1:0]          qx_ff,         qx_in;
   logic [COORD_BITS-1:0]          qy_ff,         qy_in;
   logic                           mode_ff,       mode_in;
   logic [pss_pkg::DIST_BITS-1:0]  radius_ff,     radius_in;
   logic                           rsp_valid_ff,  rsp_valid_in;
   pss_pkg::result_type            rsp_ff,        rsp_in;
   pss_pkg::tag_type               s1_tag_ff,     s1_tag_in;

   logic                           adv;
   logic                           wr_en;
   logic [COORD_BITS-1:0]          pt_x;
   logic [COORD_BITS-1:0]          pt_y;
   pss_pkg::tag_type               s3_tag;
   logic [2*COORD_BITS-1:0]        sq_x;
   logic [2*COORD_BITS-1:0]        sq_y;
   logic                           sel_emit;
   logic                           sel_done;
   pss_pkg::result_type            sel_result;

   // whole pipeline moves only when the output register can take a transaction
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && adv;

   pss_point_mem #(
      .CAPACITY   (CAPACITY),
      .COORD_BITS (COORD_BITS),
      .AW         (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_x    (req_chan.px),
      .wr_y    (req_chan.py),
      .rd_en   (adv),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_x    (pt_x),
      .rd_y    (pt_y)
   );

   pss_dist_pipe #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .tag_in  (s1_tag_ff),
      .pt_x    (pt_x),
      .pt_y    (pt_y),
      .qx      (qx_ff),
      .qy      (qy_ff),
      .tag_out (s3_tag),
      .sq_x    (sq_x),
      .sq_y    (sq_y)
   );

   pss_select #(
      .COORD_BITS (COORD_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_sel (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .mode_radius    (mode_ff),
      .radius_squared (radius_ff),
      .tag_in         (s3_tag),
      .sq_x           (sq_x),
      .sq_y           (sq_y),
      .emit           (sel_emit),
      .done           (sel_done),
      .result         (sel_result)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      mode_in      = mode_ff;
      radius_in    = radius_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      s1_tag_in    = s1_tag_ff;
      wr_en        = 1'b0;

      if (csr_we) begin
         radius_in = csr_wdata;
      end

      if (adv) begin
         rsp_valid_in    = sel_emit;
         rsp_in          = sel_result;
         s1_tag_in.valid = (state_ff == ST_SCAN) || (state_ff == ST_FINISH);
         s1_tag_in.fin   = (state_ff == ST_FINISH);
         s1_tag_in.idx   = pss_pkg::INDEX_BITS'(addr_ff);

         case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  case (pss_pkg::op_type'(req_chan.op))
                     pss_pkg::OP_CLEAR: begin
                        count_in = '0;
                     end
                     pss_pkg::OP_INSERT: begin
                        rsp_valid_in = 1'b1;
                        if (count_ff == CAP_CNT) begin
                           rsp_in = '{index: '0, dist_squared: '0, hit: 1'b0, last: 1'b1};
                        end else begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CW'(1);
                           rsp_in   = '{index: pss_pkg::INDEX_BITS'(count_ff),
                                        dist_squared: '0, hit: 1'b1, last: 1'b1};
                        end
                     end
                     pss_pkg::OP_NEAREST, pss_pkg::OP_RADIUS: begin
                        if (count_ff == '0) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = '{index: '0, dist_squared: '0, hit: 1'b0, last: 1'b1};
                        end else begin
                           qx_in    = req_chan.px;
                           qy_in    = req_chan.py;
                           mode_in  = (pss_pkg::op_type'(req_chan.op) == pss_pkg::OP_RADIUS);
                           addr_in  = '0;
                           state_in = ST_SCAN;
                        end
                     end
                     default: begin
                        count_in = count_ff;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               addr_in = addr_ff + CW'(1);
               if (addr_ff == count_ff - CW'(1)) begin
                  state_in = ST_FINISH;
               end
            end
            ST_FINISH: begin
               // closing token flushes the held result
               state_in = ST_WAIT;
            end
            ST_WAIT: begin
               if (sel_done) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         radius_ff    <= pss_pkg::RADIUS_RESET;
         rsp_valid_ff <= 1'b0;
         s1_tag_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         radius_ff    <= radius_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_tag_ff    <= s1_tag_in;
      end
      addr_ff <= addr_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      mode_ff <= mode_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.index        = rsp_ff.index;
   assign rsp_chan.dist_squared = rsp_ff.dist_squared;
   assign rsp_chan.hit          = rsp_ff.hit;
   assign rsp_chan.last         = rsp_ff.last;

endmodule

`default_nettype wire

// ===== tb/tb_point_store_nearest_and_radius_search_top.sv =====
// testbench for the point store with nearest and radius search, checked against
// an in-bench predictor; depends on pss_pkg, pss_if and the top level rtl
`timescale 1ns / 1ps

module tb_point_store_nearest_and_radius_search_top;

   localparam int CAPACITY   = 64;
   localparam int COORD_BITS = 20;
   localparam logic [pss_pkg::DIST_BITS-1:0] RADIUS_MAX = 41'd2199019061250;
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = 20'sd524287;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_we;
   logic [pss_pkg::DIST_BITS-1:0] csr_wdata;

   pss_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   pss_rsp_if                            rsp_chan ();

   point_store_nearest_and_radius_search_top #(
      .CAPACITY  (CAPACITY),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic signed [COORD_BITS-1:0]  pt_x [CAPACITY];
   logic signed [COORD_BITS-1:0]  pt_y [CAPACITY];
   int unsigned                   fill_count;
   logic [pss_pkg::DIST_BITS-1:0] radius_limit;

   pss_pkg::result_type expected_q [$];
   int                  error_count = 0;
   bit                  steady_flow = 1'b0;
   logic signed [COORD_BITS-1:0] cluster_x, cluster_y;

   function automatic pss_pkg::result_type make_result(input int idx,
                                                       input logic [pss_pkg::DIST_BITS-1:0] d,
                                                       input logic hit, input logic last);
      pss_pkg::result_type r;
      r.index        = idx[pss_pkg::INDEX_BITS-1:0];
      r.dist_squared = d;
      r.hit          = hit;
      r.last         = last;
      return r;
   endfunction

   function automatic logic [pss_pkg::DIST_BITS-1:0] sq_dist(input int i,
                                                    input logic signed [COORD_BITS-1:0] qx,
                                                    input logic signed [COORD_BITS-1:0] qy);
      longint dx;
      longint dy;
      longint s;
      dx = longint'(pt_x[i]) - longint'(qx);
      dy = longint'(pt_y[i]) - longint'(qy);
      s  = dx * dx + dy * dy;
      return s[pss_pkg::DIST_BITS-1:0];
   endfunction

   task automatic queue_expected(input pss_pkg::result_type r);
      expected_q.insert(expected_q.size(), r);
   endtask

   // expected responses of one accepted request transaction
   task automatic predict_search(input pss_pkg::op_type op,
                                 input logic signed [COORD_BITS-1:0] qx,
                                 input logic signed [COORD_BITS-1:0] qy);
      logic [pss_pkg::DIST_BITS-1:0] best_d;
      logic [pss_pkg::DIST_BITS-1:0] d;
      int                            best;
      pss_pkg::result_type           pending;
      bit                            have_pending;
      best         = 0;
      best_d       = '0;
      have_pending = 1'b0;
      pending      = '0;
      case (op)
         pss_pkg::OP_CLEAR: begin
            fill_count = 0;
         end
         pss_pkg::OP_INSERT: begin
            if (fill_count >= CAPACITY) begin
               queue_expected(make_result(0, '0, 1'b0, 1'b1));
            end else begin
               pt_x[fill_count] = qx;
               pt_y[fill_count] = qy;
               queue_expected(make_result(fill_count, '0, 1'b1, 1'b1));
               fill_count++;
            end
         end
         pss_pkg::OP_NEAREST: begin
            if (fill_count == 0) begin
               queue_expected(make_result(0, '0, 1'b0, 1'b1));
            end else begin
               best_d = sq_dist(0, qx, qy);
               for (int i = 1; i < fill_count; i++) begin
                  d = sq_dist(i, qx, qy);
                  if (d < best_d) begin
                     best_d = d;
                     best   = i;
                  end
               end
               queue_expected(make_result(best, best_d, 1'b1, 1'b1));
            end
         end
         default: begin
            // hold back each match one step so the final one can carry last
            for (int i = 0; i < fill_count; i++) begin
               d = sq_dist(i, qx, qy);
               if (d <= radius_limit) begin
                  if (have_pending) queue_expected(pending);
                  pending      = make_result(i, d, 1'b1, 1'b0);
                  have_pending = 1'b1;
               end
            end
            if (have_pending) begin
               pending.last = 1'b1;
               queue_expected(pending);
            end else begin
               queue_expected(make_result(0, '0, 1'b0, 1'b1));
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      pss_pkg::result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected transaction, index", 64'(rsp_chan.index), 64'd0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_chan.index !== want.index)
               report_mismatch("index", 64'(rsp_chan.index), 64'(want.index));
            if (rsp_chan.dist_squared !== want.dist_squared)
               report_mismatch("dist_squared", 64'(rsp_chan.dist_squared),
                               64'(want.dist_squared));
            if (rsp_chan.hit !== want.hit)
               report_mismatch("hit", 64'(rsp_chan.hit), 64'(want.hit));
            if (rsp_chan.last !== want.last)
               report_mismatch("last", 64'(rsp_chan.last), 64'(want.last));
         end
      end
   end

   // response side backpressure
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // called at a rising edge; returns at the edge the transaction is accepted
   task automatic send_item(input pss_pkg::op_type op, input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.px    <= x;
      req_chan.py    <= y;
      do @(posedge clock); while (!req_chan.ready);
      predict_search(op, x, y);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      // a clear gives no response, so leave room for it to settle
      repeat (8) @(posedge clock);
   endtask

   task automatic write_radius(input logic [pss_pkg::DIST_BITS-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      radius_limit = value;
   endtask

   function automatic logic signed [COORD_BITS-1:0] rand_coord(
         input logic signed [COORD_BITS-1:0] center);
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 3))
         0:       return r[COORD_BITS-1:0];
         // coarse grid makes equal distances likely
         1:       return COORD_BITS'(center + ((int'($urandom_range(0, 16)) - 8) * 64));
         default: return COORD_BITS'(center + (int'($urandom_range(0, 1023)) - 512));
      endcase
   endfunction

   task automatic test_empty_store();
      send_item(pss_pkg::OP_NEAREST, 20'sd0, 20'sd0);
      send_item(pss_pkg::OP_RADIUS, COORD_MAX, COORD_MIN);
      send_item(pss_pkg::OP_CLEAR, 20'sd0, 20'sd0);
      send_item(pss_pkg::OP_NEAREST, COORD_MIN, COORD_MAX);
   endtask

   task automatic test_reset_radius_and_ties();
      send_item(pss_pkg::OP_INSERT, 20'sd0, 20'sd0);
      send_item(pss_pkg::OP_INSERT, 20'sd384, 20'sd0);     // exactly on the reset radius
      send_item(pss_pkg::OP_INSERT, 20'sd385, 20'sd0);     // just outside
      send_item(pss_pkg::OP_RADIUS, 20'sd0, 20'sd0);
      send_item(pss_pkg::OP_NEAREST, 20'sd192, 20'sd0);    // tie between first two
      send_item(pss_pkg::OP_INSERT, COORD_MIN, COORD_MIN);
      send_item(pss_pkg::OP_INSERT, COORD_MAX, COORD_MAX);
      send_item(pss_pkg::OP_NEAREST, COORD_MAX, COORD_MAX);
      send_item(pss_pkg::OP_NEAREST, COORD_MIN, COORD_MAX);
      send_item(pss_pkg::OP_RADIUS, COORD_MIN, COORD_MIN);
      send_item(pss_pkg::OP_RADIUS, COORD_MIN, COORD_MAX);  // no match
      send_item(pss_pkg::OP_CLEAR, 20'sd0, 20'sd0);
      send_item(pss_pkg::OP_NEAREST, 20'sd5, 20'sd5);
   endtask

   task automatic test_radius_extremes();
      write_radius('0);
      send_item(pss_pkg::OP_INSERT, -20'sd1, 20'sd1);
      send_item(pss_pkg::OP_INSERT, 20'sd1, 20'sd1);
      send_item(pss_pkg::OP_RADIUS, -20'sd1, 20'sd1);      // exact match only
      send_item(pss_pkg::OP_RADIUS, 20'sd0, 20'sd1);       // no match at zero radius
      write_radius(RADIUS_MAX);
      send_item(pss_pkg::OP_INSERT, COORD_MIN, COORD_MIN);
      send_item(pss_pkg::OP_INSERT, COORD_MAX, COORD_MAX);
      send_item(pss_pkg::OP_RADIUS, COORD_MAX, COORD_MAX);  // farthest corner still inside
      send_item(pss_pkg::OP_NEAREST, COORD_MIN, COORD_MAX);
      send_item(pss_pkg::OP_CLEAR, 20'sd0, 20'sd0);
      write_radius(pss_pkg::RADIUS_RESET);
   endtask

   task automatic test_full_store();
      logic [31:0] r;
      write_radius(RADIUS_MAX);
      send_item(pss_pkg::OP_CLEAR, 20'sd0, 20'sd0);
      for (int i = 0; i < CAPACITY; i++) begin
         r = $urandom;
         send_item(pss_pkg::OP_INSERT, r[COORD_BITS-1:0], r[31:32-COORD_BITS]);
      end
      send_item(pss_pkg::OP_INSERT, 20'sd7, 20'sd7);       // store full, point dropped
      send_item(pss_pkg::OP_NEAREST, 20'sd7, 20'sd7);
      send_item(pss_pkg::OP_RADIUS, 20'sd0, 20'sd0);       // every stored point matches
      send_item(pss_pkg::OP_CLEAR, 20'sd0, 20'sd0);
      send_item(pss_pkg::OP_INSERT, 20'sd3, -20'sd3);
      send_item(pss_pkg::OP_CLEAR, 20'sd0, 20'sd0);
   endtask

   task automatic test_random_traffic(input int n_items);
      logic [63:0] wide;
      logic [pss_pkg::DIST_BITS-1:0] radius_pick;
      int pick;
      pss_pkg::op_type op;
      for (int phase = 0; phase < 6; phase++) begin
         wide = {$urandom, $urandom};
         case (phase)
            0: radius_pick = pss_pkg::DIST_BITS'($urandom_range(0, 300000));
            1: radius_pick = RADIUS_MAX;
            2: radius_pick = '0;
            3: begin
               radius_pick = wide[pss_pkg::DIST_BITS-1:0];
               if (radius_pick > RADIUS_MAX) radius_pick = radius_pick >> 1;
            end
            4: radius_pick = pss_pkg::DIST_BITS'($urandom_range(1000, 1 << 20));
            default: radius_pick = pss_pkg::RADIUS_RESET;
         endcase
         write_radius(radius_pick);
         steady_flow = (phase == 4);
         cluster_x = COORD_BITS'(int'($urandom_range(0, 800000)) - 400000);
         cluster_y = COORD_BITS'(int'($urandom_range(0, 800000)) - 400000);
         for (int k = 0; k < n_items / 6; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)       op = pss_pkg::OP_CLEAR;
            else if (pick < 45) op = pss_pkg::OP_INSERT;
            else if (pick < 70) op = pss_pkg::OP_NEAREST;
            else                op = pss_pkg::OP_RADIUS;
            send_item(op, rand_coord(cluster_x), rand_coord(cluster_y));
         end
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      req_chan.valid <= 1'b0;
      req_chan.op    <= pss_pkg::OP_CLEAR;
      req_chan.px    <= '0;
      req_chan.py    <= '0;
      fill_count   = 0;
      radius_limit = pss_pkg::RADIUS_RESET;
      for (int i = 0; i < CAPACITY; i++) begin
         pt_x[i] = '0;
         pt_y[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_store();
      test_reset_radius_and_ties();
      test_radius_extremes();
      test_full_store();
      test_random_traffic(108);

      wait_idle();
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pss_pkg.sv
rtl/pss_if.sv
rtl/pss_point_mem.sv
rtl/pss_dist_pipe.sv
rtl/pss_select.sv
rtl/point_store_nearest_and_radius_search_top.sv
tb/tb_point_store_nearest_and_radius_search_top.sv
